// ===== rtl/core/btea_pkg.sv =====
// ----------------------------------------------------------------------------
// btea_pkg
// Shared types and constants for the corrected block tea cipher core.
// ----------------------------------------------------------------------------
package btea_pkg;

  localparam logic [31:0] DELTA   = 32'h9e37_79b9;
  localparam int          ROUND_W = 6;

  // sequencer to datapath controls, decoded combinationally from the state
  typedef struct packed {
    logic        load;     // write the incoming word to the block store
    logic        step;     // one mixing step: write back, shift word regs
    logic        rd_b;     // registered store read into the neighbor reg
    logic        rd_out;   // registered store read into the output reg
    logic        pre_a;    // chain reg takes the neighbor reg
    logic        pre_cur;  // current-word reg takes the neighbor reg
    logic        dec;      // decrypt direction
    logic        fwd;      // two-word block: neighbor is the chain word
    logic [1:0]  key_idx;
    logic [31:0] sum;
  } btea_ctl_t;

  // full passes over the block: 6 + 52/n, for n of 2 to 31
  function automatic logic [ROUND_W-1:0] round_count(input logic [4:0] n);
    logic [ROUND_W-1:0] q;
    priority if (n <= 5'd2)  q = 6'd32;
    else if (n == 5'd3)      q = 6'd23;
    else if (n == 5'd4)      q = 6'd19;
    else if (n == 5'd5)      q = 6'd16;
    else if (n == 5'd6)      q = 6'd14;
    else if (n == 5'd7)      q = 6'd13;
    else if (n == 5'd8)      q = 6'd12;
    else if (n <= 5'd10)     q = 6'd11;
    else if (n <= 5'd13)     q = 6'd10;
    else if (n <= 5'd17)     q = 6'd9;
    else if (n <= 5'd26)     q = 6'd8;
    else                     q = 6'd7;
    return q;
  endfunction

endpackage

// ===== rtl/core/xxtea_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// xxtea_block_cipher_core
// Corrected block tea engine: loads a block of 32-bit words, encrypts or
// decrypts it in place with a 128-bit key, then streams the words back out.
// ----------------------------------------------------------------------------
//  channel  signals                              direction  transfer
//  in       in_valid/in_ready, in_data_word      to core    one block word
//  out      out_valid/out_ready, out_result_word,
//           out_last_word                        from core  one result word
//  cfg      cfg_valid/cfg_ready, cfg_index,
//           cfg_data                             to core    one register write
//
// A block of n words is loaded word by word, prefetched through states PRE0,
// PRE1 and PRE2, then mixed in q passes with q = 6 + 52/n (one mixing step
// per cycle through the single store read port) and streamed back out.
// The core takes no input while it processes or drains a block.
// Output stalls hold the current word; cfg is always ready.
// Reset returns the sequencer to block loading and restores the register defaults.
// ----------------------------------------------------------------------------
module xxtea_block_cipher_core #(
  parameter int MAX_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_word,
  output logic        out_last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_WORDS);
  localparam int CNT_W = $clog2(MAX_WORDS + 1);

  localparam logic [2:0] CFG_MODE        = 3'd0;
  localparam logic [2:0] CFG_BLOCK_WORDS = 3'd1;
  localparam logic [2:0] CFG_KEY0        = 3'd2;
  localparam logic [2:0] CFG_KEY1        = 3'd3;
  localparam logic [2:0] CFG_KEY2        = 3'd4;
  localparam logic [2:0] CFG_KEY3        = 3'd5;

  logic                 mode_r;
  logic [4:0]           block_words_r;
  logic [3:0][31:0]     key_r;
  btea_pkg::btea_ctl_t  ctl;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b0;
      block_words_r <= 5'd16;
      key_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:        mode_r        <= cfg_data[0];
        CFG_BLOCK_WORDS: block_words_r <= cfg_data[4:0];
        CFG_KEY0:        key_r[0]      <= cfg_data;
        CFG_KEY1:        key_r[1]      <= cfg_data;
        CFG_KEY2:        key_r[2]      <= cfg_data;
        CFG_KEY3:        key_r[3]      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  btea_seq #(
    .MAX_WORDS (MAX_WORDS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cfg_mode        (mode_r),
    .cfg_block_words (block_words_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_last        (out_last_word),
    .ctl             (ctl),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr)
  );

  btea_dp #(
    .MAX_WORDS (MAX_WORDS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk             (clk),
    .ctl             (ctl),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .in_data_word    (in_data_word),
    .key             (key_r),
    .out_result_word (out_result_word)
  );

endmodule

// ===== rtl/core/btea_mix.sv =====
// ----------------------------------------------------------------------------
// btea_mix
// Shared round unit: MX mixing function plus add or subtract into the word.
// ----------------------------------------------------------------------------
module btea_mix (
  input  logic [31:0] z,
  input  logic [31:0] y,
  input  logic [31:0] sum,
  input  logic [31:0] key_word,
  input  logic [31:0] cur,
  input  logic        dec,
  output logic [31:0] res
);

  logic [31:0] sh_term;
  logic [31:0] key_term;
  logic [31:0] mx;

  assign sh_term  = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
  assign key_term = (sum ^ y) + (key_word ^ z);
  assign mx       = sh_term ^ key_term;
  assign res      = dec ? (cur - mx) : (cur + mx);

endmodule

// ===== rtl/core/btea_dp.sv =====
// ----------------------------------------------------------------------------
// btea_dp
// Block store, word registers and the shared round unit.
// ----------------------------------------------------------------------------
module btea_dp #(
  parameter int MAX_WORDS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  btea_pkg::btea_ctl_t  ctl,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [31:0]          in_data_word,
  input  logic [3:0][31:0]     key,
  output logic [31:0]          out_result_word
);

  logic [31:0] mem [MAX_WORDS];
  logic [31:0] a_r;        // chain word: z when encrypting, y when decrypting
  logic [31:0] b_r;        // neighbor word read from the store
  logic [31:0] cur_r;      // word being updated
  logic [31:0] out_word_r;
  logic [31:0] b_eff;
  logic [31:0] z;
  logic [31:0] y;
  logic [31:0] new_word;

  assign b_eff = ctl.fwd ? a_r : b_r;
  assign z     = ctl.dec ? b_eff : a_r;
  assign y     = ctl.dec ? a_r : b_eff;

  btea_mix u_mix (
    .z        (z),
    .y        (y),
    .sum      (ctl.sum),
    .key_word (key[ctl.key_idx]),
    .cur      (cur_r),
    .dec      (ctl.dec),
    .res      (new_word)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[wr_addr] <= in_data_word;
    end else if (ctl.step) begin
      mem[wr_addr] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_b) begin
      b_r <= mem[rd_addr];
    end
    if (ctl.rd_out) begin
      out_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre_a) begin
      a_r <= b_r;
    end else if (ctl.step) begin
      a_r <= new_word;
    end
    if (ctl.pre_cur) begin
      cur_r <= b_r;
    end else if (ctl.step) begin
      cur_r <= b_eff;
    end
  end

  assign out_result_word = out_word_r;

endmodule

// ===== rtl/core/btea_seq.sv =====
// ----------------------------------------------------------------------------
// btea_seq
// Sequencer: block loading, prefetch, round and step counting, drain.
// ----------------------------------------------------------------------------
module btea_seq #(
  parameter int MAX_WORDS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_mode,
  input  logic [4:0]           cfg_block_words,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  output btea_pkg::btea_ctl_t  ctl,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [IDX_W-1:0]     rd_addr
);

  localparam int AW1 = IDX_W + 1;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_PRE0 = 7'b0000010,
    S_PRE1 = 7'b0000100,
    S_PRE2 = 7'b0001000,
    S_RUN  = 7'b0010000,
    S_OUT0 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IDX_W-1:0]              ld_cnt_r, ld_cnt_nxt;
  logic [CNT_W-1:0]              n_r, n_nxt;
  logic                          dec_r, dec_nxt;
  logic [IDX_W-1:0]              p_r, p_nxt;
  logic [IDX_W-1:0]              k_r, k_nxt;
  logic [btea_pkg::ROUND_W-1:0]  rounds_r, rounds_nxt;
  logic [31:0]                   sum_r, sum_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CNT_W-1:0]              n_eff;
  logic                          ld_restart;
  logic [IDX_W-1:0]              ld_addr;
  logic                          ld_last;
  logic                          in_fire;
  logic [IDX_W-1:0]              nm1;
  logic [IDX_W-1:0]              nm2;
  logic [btea_pkg::ROUND_W-1:0]  q_tab;
  logic [31:0]                   dec_sum0;
  logic                          p_last;
  logic [IDX_W-1:0]              p_step;
  logic [AW1-1:0]                rd_fwd;
  logic [AW1-1:0]                rd_bwd;
  logic [IDX_W-1:0]              run_rd;
  logic [IDX_W-1:0]              k_inc;

  // word count clamped to the store and to at least two
  always_comb begin
    priority if (cfg_block_words < 5'd2) begin
      n_eff = CNT_W'(2);
    end else if (32'(cfg_block_words) > MAX_WORDS) begin
      n_eff = CNT_W'(MAX_WORDS);
    end else begin
      n_eff = CNT_W'(cfg_block_words);
    end
  end

  assign in_ready   = (state_r == S_LOAD);
  assign in_fire    = in_valid & in_ready;
  // a shrunk word count drops the partial block
  assign ld_restart = (CNT_W'(ld_cnt_r) >= n_eff);
  assign ld_addr    = ld_restart ? '0 : ld_cnt_r;
  assign ld_last    = (CNT_W'(ld_addr) == (n_eff - CNT_W'(1)));

  assign nm1      = IDX_W'(n_r - CNT_W'(1));
  assign nm2      = IDX_W'(n_r - CNT_W'(2));
  assign q_tab    = btea_pkg::round_count(5'(n_r));
  assign dec_sum0 = 32'(q_tab) * btea_pkg::DELTA;

  // step order: up through the block when encrypting, down when decrypting
  assign p_last = dec_r ? (p_r == '0) : (p_r == nm1);
  always_comb begin
    if (dec_r) begin
      p_step = p_last ? nm1 : (p_r - IDX_W'(1));
    end else begin
      p_step = p_last ? '0 : (p_r + IDX_W'(1));
    end
  end

  // neighbor two places ahead when encrypting, two behind when decrypting, modulo the word count
  assign rd_fwd = (AW1'(p_r) + AW1'(2) >= AW1'(n_r)) ?
                  (AW1'(p_r) + AW1'(2) - AW1'(n_r)) : (AW1'(p_r) + AW1'(2));
  assign rd_bwd = (p_r >= IDX_W'(2)) ? (AW1'(p_r) - AW1'(2)) :
                  (AW1'(p_r) + AW1'(n_r) - AW1'(2));
  assign run_rd = dec_r ? IDX_W'(rd_bwd) : IDX_W'(rd_fwd);
  assign k_inc  = k_r + IDX_W'(1);

  always_comb begin
    state_nxt     = state_r;
    ld_cnt_nxt    = ld_cnt_r;
    n_nxt         = n_r;
    dec_nxt       = dec_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    rounds_nxt    = rounds_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    ctl.dec       = dec_r;
    ctl.fwd       = (n_r == CNT_W'(2));
    ctl.key_idx   = 2'(p_r) ^ sum_r[3:2];
    ctl.sum       = sum_r;
    wr_addr       = ld_addr;
    rd_addr       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          ctl.load = 1'b1;
          if (ld_last) begin
            ld_cnt_nxt = '0;
            n_nxt      = n_eff;
            dec_nxt    = cfg_mode;
            state_nxt  = S_PRE0;
          end else begin
            ld_cnt_nxt = ld_addr + IDX_W'(1);
          end
        end
      end
      S_PRE0: begin
        rd_addr    = dec_r ? '0 : nm1;
        ctl.rd_b   = 1'b1;
        rounds_nxt = q_tab;
        sum_nxt    = dec_r ? dec_sum0 : btea_pkg::DELTA;
        state_nxt  = S_PRE1;
      end
      S_PRE1: begin
        rd_addr   = dec_r ? nm1 : '0;
        ctl.rd_b  = 1'b1;
        ctl.pre_a = 1'b1;
        state_nxt = S_PRE2;
      end
      S_PRE2: begin
        rd_addr     = dec_r ? nm2 : IDX_W'(1);
        ctl.rd_b    = 1'b1;
        ctl.pre_cur = 1'b1;
        p_nxt       = dec_r ? nm1 : '0;
        state_nxt   = S_RUN;
      end
      S_RUN: begin
        ctl.step = 1'b1;
        ctl.rd_b = 1'b1;
        wr_addr  = p_r;
        rd_addr  = run_rd;
        p_nxt    = p_step;
        if (p_last) begin
          if (rounds_r == btea_pkg::ROUND_W'(1)) begin
            state_nxt = S_OUT0;
          end else begin
            rounds_nxt = rounds_r - btea_pkg::ROUND_W'(1);
            sum_nxt    = dec_r ? (sum_r - btea_pkg::DELTA) : (sum_r + btea_pkg::DELTA);
          end
        end
      end
      S_OUT0: begin
        rd_addr       = '0;
        ctl.rd_out    = 1'b1;
        k_nxt         = '0;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b0;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (k_r == nm1) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_LOAD;
          end else begin
            k_nxt        = k_inc;
            rd_addr      = k_inc;
            ctl.rd_out   = 1'b1;
            out_last_nxt = (k_inc == nm1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ld_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    dec_r      <= dec_nxt;
    p_r        <= p_nxt;
    k_r        <= k_nxt;
    rounds_r   <= rounds_nxt;
    sum_r      <= sum_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;

endmodule
